>>> sv/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int SUM_W    = CH_W + 1;
  localparam int PAIR_W   = SUM_W * NUM_CH;
  localparam int WREG_W   = 12;
  localparam int HREG_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(2048);
  localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(2048);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic wr;
    logic rd;
    logic last;
  } rbd_ctl_t;

  // horizontal pair sums, 9 bits per channel
  function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PAIR_W-1:0] s;
    s = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s[ch*SUM_W +: SUM_W] = SUM_W'(a[ch*CH_W +: CH_W]) + SUM_W'(b[ch*CH_W +: CH_W]);
    end
    return s;
  endfunction

  // vertical add of two pair sums, divided by four
  function automatic logic [PIX_W-1:0] box_avg(input logic [PAIR_W-1:0] a,
                                               input logic [PAIR_W-1:0] b);
    logic [PIX_W-1:0] p;
    logic [SUM_W:0]   t;
    p = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      t = (SUM_W+1)'(a[ch*SUM_W +: SUM_W]) + (SUM_W+1)'(b[ch*SUM_W +: SUM_W]);
      p[ch*CH_W +: CH_W] = t[SUM_W:2];
    end
    return p;
  endfunction

endpackage

>>> sv/rgba_box_downsample_2x2.sv
`timescale 1ns / 1ps

// 2x2 box downsampler for an RGBA raster: takes one pixel per clock in raster
// order, unless a stalled output holds in_tready low, and emits one pixel per
// 2x2 block, each channel the block sum shifted right by two. Even rows park
// their horizontal pair sums in a half-line memory (MAX_WIDTH/2 entries, one
// access per pixel pair); odd rows read the entry back, and the averaged pixel
// passes through the s1 read stage and then the output register. A trailing
// odd column or row produces nothing, out_tlast marks the final pixel of each
// downsampled frame, and the position counters wrap for the next frame. Program
// image_width and image_height only between frames, while the block is idle.

module rgba_box_downsample_2x2
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
  localparam int AW    = CW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;

  logic              acc;
  rbd_ctl_t          ctl;
  logic [AW-1:0]     addr;
  logic [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0] rd_data;

  logic              s1_v_r, s1_v_nxt;
  logic [PAIR_W-1:0] s1_pair_r;
  logic              s1_last_r;
  logic              s1_adv;

  logic              out_v_r, out_v_nxt;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || !out_v_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  rbd_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_acc  (acc),
    .pix      (in_tdata),
    .ctl      (ctl),
    .addr     (addr),
    .pair     (pair)
  );

  rbd_linebuf #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_linebuf (
    .clk    (clk),
    .wr_en  (ctl.wr),
    .rd_en  (ctl.rd),
    .addr   (addr),
    .wr_data(pair),
    .rd_data(rd_data)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (ctl.rd) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      s1_pair_r <= pair;
      s1_last_r <= ctl.last;
    end
    if (s1_adv) begin
      out_data_r <= box_avg(rd_data, s1_pair_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/rbd_linebuf.sv
`timescale 1ns / 1ps

module rbd_linebuf
  import rbd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH / 2,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr,
  input  logic [PAIR_W-1:0] wr_data,
  output logic [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem [DEPTH];
  logic [PAIR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/rbd_scan.sv
`timescale 1ns / 1ps

module rbd_scan
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_acc,
  input  logic [PIX_W-1:0]      pix,
  output rbd_ctl_t              ctl,
  output logic [((MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2)-2:0] addr,
  output logic [PAIR_W-1:0]     pair
);

  localparam int CW  = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
  localparam int EW0 = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EW0 > WREG_W) ? EW0 : WREG_W;

  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [HREG_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0]  held_r;

  logic [EW-1:0]     eff_w;
  logic [HREG_W-1:0] eff_h;
  logic [EW-1:0]     col_inc;
  logic [HREG_W:0]   row_inc;
  logic              at_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    eff_h = (height_r == '0) ? HREG_W'(1) : height_r;
  end

  assign col_inc = EW'(col_r) + EW'(1);
  assign row_inc = (HREG_W+1)'(row_r) + (HREG_W+1)'(1);

  always_comb begin
    col_nxt = CW'(col_inc);
    row_nxt = row_r;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = row_inc[HREG_W-1:0];
      if (row_inc >= (HREG_W+1)'(eff_h)) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (pix_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!col_r[0]) begin
        held_r <= pix;
      end
    end
  end

  assign at_last = (eff_w >= EW'(2)) && (eff_h >= HREG_W'(2))
                && (EW'(col_r) == ((eff_w & ~EW'(1)) - EW'(1)))
                && (row_r == ((eff_h & ~HREG_W'(1)) - HREG_W'(1)));

  assign pair     = pair_sum(held_r, pix);
  assign addr     = col_r[CW-1:1];
  assign ctl.wr   = pix_acc && col_r[0] && !row_r[0];
  assign ctl.rd   = pix_acc && col_r[0] && row_r[0];
  assign ctl.last = at_last;

endmodule
